// File: rtl/dpsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Distance PID servo controller package
// Shared widths, limits, register map and types of the servo controller.
// ----------------------------------------------------------------------------
package dpsc_pkg;

  // Field widths.
  localparam int RawW    = 16;
  localparam int DistW   = 11;
  localparam int GainW   = 16;
  localparam int AngleW  = 8;
  localparam int ServoW  = 16;
  localparam int ErrW    = 12;
  localparam int DiffW   = 13;
  localparam int SumW    = 15;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 16;

  // Product and drive widths (unsigned gain times signed operand).
  localparam int PropW  = GainW + 1 + ErrW;
  localparam int DerivW = GainW + 1 + DiffW;
  localparam int IntegW = GainW + 1 + SumW;
  localparam int DriveW = IntegW;
  localparam int Q8W    = DriveW - 8;
  localparam int PosW   = Q8W + 2;

  // Limits.
  localparam logic [DistW-1:0] DistMax = 11'd2000;
  localparam logic signed [SumW-1:0] SumMin = -15'sd10000;
  localparam logic signed [SumW-1:0] SumMax = 15'sd10000;

  // Moving-average window default.
  localparam int WindowDefault = 5;

  // Register reset values.
  localparam logic [GainW-1:0]  PropGainRst   = 16'd7995;
  localparam logic [GainW-1:0]  DerivGainRst  = 16'd15139;
  localparam logic [GainW-1:0]  IntegGainRst  = 16'd262;
  localparam logic [DistW-1:0]  TargetRst     = 11'd150;
  localparam logic [AngleW-1:0] CenterRst     = 8'd130;
  localparam logic [AngleW-1:0] FloorRst      = 8'd60;
  localparam logic [AngleW-1:0] CeilingRst    = 8'd165;
  localparam logic              EnableRst     = 1'b1;

  // Register map.
  typedef enum logic [CfgIdxW-1:0] {
    CfgPropGain   = 3'd0,
    CfgDerivGain  = 3'd1,
    CfgIntegGain  = 3'd2,
    CfgTarget     = 3'd3,
    CfgCenter     = 3'd4,
    CfgFloor      = 3'd5,
    CfgCeiling    = 3'd6,
    CfgPidEnable  = 3'd7
  } cfg_idx_e;

  // Configuration seen by the PID datapath.
  typedef struct packed {
    logic [GainW-1:0]  prop_gain;
    logic [GainW-1:0]  deriv_gain;
    logic [GainW-1:0]  integ_gain;
    logic [DistW-1:0]  target_distance;
    logic [AngleW-1:0] center_angle;
    logic [AngleW-1:0] angle_floor;
    logic [AngleW-1:0] angle_ceiling;
    logic              pid_enable;
  } pid_cfg_t;

  // Result register contents handed to the top level.
  typedef struct packed {
    logic              valid;
    logic [DistW-1:0]  mean_distance;
    logic [ServoW-1:0] servo_angle;
    logic              angle_valid;
  } result_t;

endpackage : dpsc_pkg
`default_nettype wire

// File: rtl/distance_pid_servo_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Distance PID servo controller
// Moving-average distance filter followed by a PID servo angle controller.
// ----------------------------------------------------------------------------
// The block accepts one distance sample per clock cycle while the pipeline
// advances and returns one result per sample, in order. The ring and running
// total update on the accepting edge; the mean register, the register of the
// three gain products and the output register, which takes the clamped angle,
// follow in that order. The whole pipeline moves together whenever the output
// register is empty or being drained, so s_axis_tready is high in exactly
// those cases and a full rate of one request per cycle is kept as long as the
// downstream side keeps up.
// Configuration writes take effect on the next edge and should only be made
// while no request is in flight.
module distance_pid_servo_controller_unit #(
  parameter int WINDOW = dpsc_pkg::WindowDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input stream.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,  // [15:0] raw_distance
  // Output stream.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [31:0]                        m_axis_tdata,  // [10:0] mean_distance,
                                                            // [26:11] servo_angle
  output logic                               m_axis_tuser,  // [0] angle_valid
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [dpsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dpsc_pkg::CfgDatW-1:0]  cfg_wdata_i
);

  localparam int DistW = dpsc_pkg::DistW;

  dpsc_pkg::pid_cfg_t cfg_q;
  dpsc_pkg::result_t  result;
  logic               advance;
  logic               mean_valid;
  logic [DistW-1:0]   mean_distance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= dpsc_pkg::PropGainRst;
      cfg_q.deriv_gain      <= dpsc_pkg::DerivGainRst;
      cfg_q.integ_gain      <= dpsc_pkg::IntegGainRst;
      cfg_q.target_distance <= dpsc_pkg::TargetRst;
      cfg_q.center_angle    <= dpsc_pkg::CenterRst;
      cfg_q.angle_floor     <= dpsc_pkg::FloorRst;
      cfg_q.angle_ceiling   <= dpsc_pkg::CeilingRst;
      cfg_q.pid_enable      <= dpsc_pkg::EnableRst;
    end else if (cfg_we_i) begin
      unique case (dpsc_pkg::cfg_idx_e'(cfg_idx_i))
        dpsc_pkg::CfgPropGain:  cfg_q.prop_gain       <= cfg_wdata_i;
        dpsc_pkg::CfgDerivGain: cfg_q.deriv_gain      <= cfg_wdata_i;
        dpsc_pkg::CfgIntegGain: cfg_q.integ_gain      <= cfg_wdata_i;
        dpsc_pkg::CfgTarget:    cfg_q.target_distance <= cfg_wdata_i[DistW-1:0];
        dpsc_pkg::CfgCenter:    cfg_q.center_angle    <= cfg_wdata_i[dpsc_pkg::AngleW-1:0];
        dpsc_pkg::CfgFloor:     cfg_q.angle_floor     <= cfg_wdata_i[dpsc_pkg::AngleW-1:0];
        dpsc_pkg::CfgCeiling:   cfg_q.angle_ceiling   <= cfg_wdata_i[dpsc_pkg::AngleW-1:0];
        dpsc_pkg::CfgPidEnable: cfg_q.pid_enable      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // The pipeline advances when the output register is free or being taken.
  assign advance       = !result.valid | m_axis_tready;
  assign s_axis_tready = advance;

  dpsc_avg #(
    .WINDOW (WINDOW)
  ) u_avg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .in_valid_i      (s_axis_tvalid),
    .raw_distance_i  (s_axis_tdata),
    .mean_valid_o    (mean_valid),
    .mean_distance_o (mean_distance)
  );

  dpsc_pid u_pid (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .mean_valid_i    (mean_valid),
    .mean_distance_i (mean_distance),
    .cfg_i           (cfg_q),
    .result_o        (result)
  );

  // Output stream packing.
  assign m_axis_tvalid = result.valid;
  assign m_axis_tdata  = {5'b0, result.servo_angle, result.mean_distance};
  assign m_axis_tuser  = result.angle_valid;

  // A request cannot enter while a finished result is stuck downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");

endmodule : distance_pid_servo_controller_unit
`default_nettype wire

// File: rtl/dpsc_avg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving-average front end
// Clamps each sample, keeps a ring of the last WINDOW samples with a running
// total, and registers the truncated mean one stage later.
// ----------------------------------------------------------------------------
module dpsc_avg #(
  parameter int WINDOW = dpsc_pkg::WindowDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       advance_i,
  input  wire logic                       in_valid_i,
  input  wire logic [dpsc_pkg::RawW-1:0]  raw_distance_i,
  output logic                            mean_valid_o,
  output logic [dpsc_pkg::DistW-1:0]      mean_distance_o
);

  localparam int DistW      = dpsc_pkg::DistW;
  localparam int SlotW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TotalW     = $clog2(WINDOW * 2000 + 1);
  // Reciprocal with four guard bits is exact for every total below 2^TotalW.
  localparam int RecipShift = TotalW + 4;
  localparam int RecipW     = RecipShift + 1;
  localparam int ProdW      = TotalW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipShift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WINDOW - 1);
  localparam logic [TotalW-1:0] TotalMax = TotalW'(WINDOW * 2000);

  logic                 accept;
  logic [DistW-1:0]     sample;
  logic [DistW-1:0]     ring_q [WINDOW];
  logic [SlotW-1:0]     slot_q, slot_d;
  logic [TotalW-1:0]    total_q, total_d;
  logic                 total_valid_q;
  logic [ProdW-1:0]     prod;
  logic                 mean_valid_q;
  logic [DistW-1:0]     mean_q;

  assign accept = in_valid_i & advance_i;

  // Clamp the raw reading to the sensor range.
  always_comb begin
    if (raw_distance_i > dpsc_pkg::RawW'(dpsc_pkg::DistMax)) begin
      sample = dpsc_pkg::DistMax;
    end else begin
      sample = raw_distance_i[DistW-1:0];
    end
  end

  // Running total replaces the oldest sample with the new one.
  assign total_d = total_q - TotalW'(ring_q[slot_q]) + TotalW'(sample);
  assign slot_d  = (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW; k++) begin
        ring_q[k] <= '0;
      end
      slot_q  <= '0;
      total_q <= '0;
    end else if (accept) begin
      ring_q[slot_q] <= sample;
      slot_q         <= slot_d;
      total_q        <= total_d;
    end
  end

  // Mean by multiplying with the scaled reciprocal of the window length.
  assign prod = ProdW'(total_q) * ProdW'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_valid_q <= 1'b0;
      mean_valid_q  <= 1'b0;
    end else if (advance_i) begin
      total_valid_q <= in_valid_i;
      mean_valid_q  <= total_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      mean_q <= prod[RecipShift +: DistW];
    end
  end

  assign mean_valid_o    = mean_valid_q;
  assign mean_distance_o = mean_q;

  // The running total never exceeds a full window of maximum samples.
  assert property (@(posedge clk_i) disable iff (!rst_ni) total_q <= TotalMax)
    else $error("running total above window maximum");

  // The write slot stays inside the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni) slot_q <= LastSlot)
    else $error("ring write slot out of range");

endmodule : dpsc_avg
`default_nettype wire

// File: rtl/dpsc_pid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID stage and servo angle output register
// Forms the error terms and gain products in one stage, then sums, scales,
// offsets and clamps the angle into the result register.
// ----------------------------------------------------------------------------
module dpsc_pid (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       advance_i,
  input  wire logic                       mean_valid_i,
  input  wire logic [dpsc_pkg::DistW-1:0] mean_distance_i,
  input  wire dpsc_pkg::pid_cfg_t         cfg_i,
  output dpsc_pkg::result_t               result_o
);

  localparam int DistW  = dpsc_pkg::DistW;
  localparam int ErrW   = dpsc_pkg::ErrW;
  localparam int DiffW  = dpsc_pkg::DiffW;
  localparam int SumW   = dpsc_pkg::SumW;
  localparam int PropW  = dpsc_pkg::PropW;
  localparam int DerivW = dpsc_pkg::DerivW;
  localparam int IntegW = dpsc_pkg::IntegW;
  localparam int DriveW = dpsc_pkg::DriveW;
  localparam int Q8W    = dpsc_pkg::Q8W;
  localparam int PosW   = dpsc_pkg::PosW;
  localparam int ServoW = dpsc_pkg::ServoW;

  logic signed [ErrW-1:0]   err;
  logic signed [DiffW-1:0]  diff;
  logic signed [SumW-1:0]   sum_raw;
  logic signed [SumW-1:0]   sum_clamped;
  logic signed [PropW-1:0]  prop_d, prop_q;
  logic signed [DerivW-1:0] deriv_d, deriv_q;
  logic signed [IntegW-1:0] integ_d, integ_q;
  logic signed [ErrW-1:0]   prev_err_q;
  logic signed [SumW-1:0]   err_sum_q;
  logic                     prod_valid_q;
  logic                     pid_on_q;
  logic [DistW-1:0]         prod_mean_q;
  logic                     run_pid;

  logic signed [DriveW-1:0] drive;
  logic signed [Q8W-1:0]    drive_q8;
  logic signed [PosW-1:0]   angle;
  logic signed [PosW-1:0]   angle_lo;
  logic signed [PosW-1:0]   angle_hi;
  logic signed [PosW-1:0]   angle_raised;
  logic signed [PosW-1:0]   angle_clamped;
  dpsc_pkg::result_t        result_q;

  assign run_pid = advance_i & mean_valid_i & cfg_i.pid_enable;

  // Error, its change and the unclamped accumulated sum.
  assign err     = $signed({1'b0, mean_distance_i}) - $signed({1'b0, cfg_i.target_distance});
  assign diff    = DiffW'(err) - DiffW'(prev_err_q);
  assign sum_raw = err_sum_q + SumW'(err);

  always_comb begin
    if (sum_raw < dpsc_pkg::SumMin) begin
      sum_clamped = dpsc_pkg::SumMin;
    end else if (sum_raw > dpsc_pkg::SumMax) begin
      sum_clamped = dpsc_pkg::SumMax;
    end else begin
      sum_clamped = sum_raw;
    end
  end

  // Gain products; the integral product uses the sum before clamping.
  assign prop_d  = PropW'($signed({1'b0, cfg_i.prop_gain})) * PropW'(err);
  assign deriv_d = DerivW'($signed({1'b0, cfg_i.deriv_gain})) * DerivW'(diff);
  assign integ_d = IntegW'($signed({1'b0, cfg_i.integ_gain})) * IntegW'(sum_raw);

  // Controller history advances only for items that ran the PID.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      err_sum_q  <= '0;
    end else if (run_pid) begin
      prev_err_q <= err;
      err_sum_q  <= sum_clamped;
    end
  end

  // Product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (advance_i) begin
      prod_valid_q <= mean_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      prop_q      <= prop_d;
      deriv_q     <= deriv_d;
      integ_q     <= integ_d;
      pid_on_q    <= cfg_i.pid_enable;
      prod_mean_q <= mean_distance_i;
    end
  end

  // Drive in Q16, floored to Q8, offset by the center and clamped.
  assign drive    = DriveW'(prop_q) + DriveW'(deriv_q) + integ_q;
  assign drive_q8 = drive[DriveW-1:8];
  assign angle    = $signed(PosW'({cfg_i.center_angle, 8'b0})) + PosW'(drive_q8);
  assign angle_lo = $signed(PosW'({cfg_i.angle_floor, 8'b0}));
  assign angle_hi = $signed(PosW'({cfg_i.angle_ceiling, 8'b0}));

  always_comb begin
    angle_raised  = (angle < angle_lo) ? angle_lo : angle;
    angle_clamped = (angle_raised > angle_hi) ? angle_hi : angle_raised;
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q <= '0;
    end else if (advance_i) begin
      result_q.valid         <= prod_valid_q;
      result_q.mean_distance <= prod_mean_q;
      result_q.angle_valid   <= pid_on_q;
      result_q.servo_angle   <= pid_on_q ? angle_clamped[ServoW-1:0] : '0;
    end
  end

  assign result_o = result_q;

  // The stored accumulator stays within its clamp window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_sum_q >= dpsc_pkg::SumMin) && (err_sum_q <= dpsc_pkg::SumMax))
    else $error("error accumulator outside clamp window");

  // A result without a new command carries a zero angle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_q.valid && !result_q.angle_valid) |-> (result_q.servo_angle == '0))
    else $error("servo angle not zero while PID is off");

  // History must not move while the PID is switched off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_i.pid_enable |=> ($stable(err_sum_q) && $stable(prev_err_q)))
    else $error("PID history changed while disabled");

endmodule : dpsc_pid
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance PID servo controller testbench
// Streams range samples through the controller under a series of register
// settings and idle patterns. A scoreboard keeps its own moving-average and
// PID state, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import dpsc_pkg::*;

  localparam int WindowLen     = 5;
  localparam int PipeDepth     = 3;
  localparam int NumRegs       = 8;
  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 165;
  localparam int HoldCycles    = 400;
  localparam int MaxReports    = 10;
  localparam int TimeoutNs     = 2_000_000;

  // Corner samples sent under the reset register values. The long run of
  // saturated readings pushes the integral into its upper clamp, the zeros
  // that follow swing the error the other way.
  localparam logic [RawW-1:0] CornerDistances [20] = '{
    16'd0,     16'hFFFF,  16'd2000,  16'd2001,  16'd1999,
    16'd1,     16'h8000,  16'h5555,  16'hAAAA,  16'h07FF,
    16'h0800,  16'd150,   16'hFFFF,  16'hFFFF,  16'hFFFF,
    16'hFFFF,  16'd0,     16'd0,     16'd0,     16'd0
  };

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct {
    logic [DistW-1:0]  mean;
    logic [ServoW-1:0] angle;
    logic              angle_valid;
  } servo_result_t;

  // Scoreboard: mirrors the filter and PID state and queues predicted results.
  class servo_scoreboard;
    pid_cfg_t          cfg;
    logic [DistW-1:0]  ring [WindowLen];
    int unsigned       slot;
    longint            last_err;
    longint            err_acc;
    servo_result_t     expected_cmds [$];
    int unsigned       errors;
    int unsigned       samples;
    int unsigned       checked;
    int unsigned       pid_runs;

    function new();
      cfg.prop_gain       = PropGainRst;
      cfg.deriv_gain      = DerivGainRst;
      cfg.integ_gain      = IntegGainRst;
      cfg.target_distance = TargetRst;
      cfg.center_angle    = CenterRst;
      cfg.angle_floor     = FloorRst;
      cfg.angle_ceiling   = CeilingRst;
      cfg.pid_enable      = EnableRst;
      foreach (ring[k]) ring[k] = '0;
      slot     = 0;
      last_err = 0;
      err_acc  = 0;
      errors   = 0;
      samples  = 0;
      checked  = 0;
      pid_runs = 0;
    endfunction

    // Register writes keep only the bits the register holds.
    function void apply_reg(cfg_idx_e idx, logic [CfgDatW-1:0] val);
      case (idx)
        CfgPropGain:  cfg.prop_gain       = val[GainW-1:0];
        CfgDerivGain: cfg.deriv_gain      = val[GainW-1:0];
        CfgIntegGain: cfg.integ_gain      = val[GainW-1:0];
        CfgTarget:    cfg.target_distance = val[DistW-1:0];
        CfgCenter:    cfg.center_angle    = val[AngleW-1:0];
        CfgFloor:     cfg.angle_floor     = val[AngleW-1:0];
        CfgCeiling:   cfg.angle_ceiling   = val[AngleW-1:0];
        CfgPidEnable: cfg.pid_enable      = val[0];
        default: ;
      endcase
    endfunction

    // Predicts the filtered distance and servo command for one request.
    function void note_distance(logic [RawW-1:0] raw);
      logic [DistW-1:0] clamped;
      int unsigned      total;
      longint           err;
      longint           diff;
      longint           acc;
      longint           drive;
      longint           angle;
      longint           lo;
      longint           hi;
      servo_result_t    res;
      clamped = (raw > DistMax) ? DistMax : raw[DistW-1:0];
      ring[slot] = clamped;
      slot = (slot + 1) % WindowLen;
      total = 0;
      foreach (ring[k]) total += ring[k];
      res.mean        = DistW'(total / WindowLen);
      res.angle       = '0;
      res.angle_valid = 1'b0;
      samples++;

      if (cfg.pid_enable) begin
        err   = longint'(res.mean) - longint'(cfg.target_distance);
        diff  = err - last_err;
        acc   = err_acc + err;
        // The integral term sees the sum before it is clamped.
        drive = longint'(cfg.prop_gain) * err + longint'(cfg.deriv_gain) * diff
              + longint'(cfg.integ_gain) * acc;
        angle = (longint'(cfg.center_angle) <<< 8) + (drive >>> 8);
        lo    = longint'(cfg.angle_floor) <<< 8;
        hi    = longint'(cfg.angle_ceiling) <<< 8;
        // The ceiling is applied last, so it wins when the limits cross.
        if (angle < lo) angle = lo;
        if (angle > hi) angle = hi;
        last_err = err;
        if (acc < longint'(SumMin)) acc = longint'(SumMin);
        if (acc > longint'(SumMax)) acc = longint'(SumMax);
        err_acc = acc;
        res.angle       = angle[ServoW-1:0];
        res.angle_valid = 1'b1;
        pid_runs++;
      end
      expected_cmds.push_back(res);
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= MaxReports) $display("[%0t] MISMATCH: %s", $realtime, what);
    endfunction

    // Compares one delivered result with the oldest prediction.
    function void check_result(logic [DistW-1:0] mean, logic [ServoW-1:0] angle,
                               logic angle_valid);
      servo_result_t want;
      if (expected_cmds.size() == 0) begin
        flag($sformatf("result mean=%0d angle=%0d valid=%0b with no request pending",
                       mean, angle, angle_valid));
        return;
      end
      want = expected_cmds.pop_front();
      checked++;
      if (want.mean != mean || want.angle != angle || want.angle_valid !== angle_valid)
        flag($sformatf({"result %0d: mean exp %0d got %0d, angle exp %0d got %0d, ",
                        "valid exp %0b got %0b"}, checked, want.mean, mean,
                       want.angle, angle, want.angle_valid, angle_valid));
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [RawW-1:0]      s_axis_tdata;   // [15:0] raw_distance
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [31:0]          m_axis_tdata;   // [10:0] mean_distance, [26:11] servo_angle
  logic                 m_axis_tuser;   // [0] angle_valid
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDatW-1:0]   cfg_wdata_i;

  servo_scoreboard sb = new();
  int              src_idle_pct   = 0;
  int              sink_stall_pct = 0;
  int              hold_requests  = 0;
  int              settings_used  = 1;

  distance_pid_servo_controller_unit #(
    .WINDOW(WindowLen)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #(TimeoutNs);
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: checks every accepted result and stalls at random. A hold
  // request from the stimulus makes it refuse results for a long stretch.
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[DistW-1:0], m_axis_tdata[DistW+ServoW-1:DistW],
                        m_axis_tuser);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Offers one distance request, with random gaps, and notes it once taken.
  task automatic send_distance(input logic [RawW-1:0] raw);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= RawW'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_distance(raw);
  endtask

  // Waits until every predicted result has come back and the pipeline is empty.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PipeDepth + 1) @(posedge clk_i);
  endtask

  // Writes all registers for one test phase, in register map order.
  task automatic load_phase(input int p);
    logic [CfgDatW-1:0] v [NumRegs];
    cfg_idx_e           idx;
    case (p)
      0: v = '{16'd20000, 16'd30000, 16'd1000, 16'd800, 16'd90, 16'd0, 16'd180, 16'd1};
      // Everything at zero: the servo always sits at angle zero.
      1: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
      // All ones: target and angles beyond their stated ranges.
      2: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               16'hFFFF, 16'hFFFF};
      // Floor above ceiling.
      3: v = '{16'd40000, 16'd5000, 16'd3000, 16'd1000, 16'd90, 16'd170, 16'd20, 16'd1};
      // PID off; only bit zero of the enable counts.
      4: v = '{16'd7995, 16'd15139, 16'd262, 16'd150, 16'd130, 16'd60, 16'd165, 16'hFFFE};
      5: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1000, 16'd180, 16'd0, 16'd180, 16'd1};
      // Far target, so the integral runs into its lower clamp.
      6: v = '{16'd7995, 16'd15139, 16'd262, 16'd2000, 16'd130, 16'd60, 16'd165, 16'd1};
      default: begin
        foreach (v[i]) v[i] = CfgDatW'($urandom);
        v[int'(CfgPidEnable)] = CfgDatW'($urandom_range(3) != 0);
      end
    endcase
    idx = idx.first();
    forever begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= v[int'(idx)];
      @(posedge clk_i);
      sb.apply_reg(idx, v[int'(idx)]);
      if (idx == idx.last()) break;
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Mostly readings within the sensor range, some near the target, some noise.
  function automatic logic [RawW-1:0] pick_distance();
    int unsigned roll;
    int          t;
    roll = $urandom_range(99);
    if (roll < 55) return RawW'($urandom_range(DistMax));
    if (roll < 75) begin
      t = int'(sb.cfg.target_distance) + int'($urandom_range(200)) - 100;
      if (t < 0) t = 0;
      if (t > int'(DistMax)) t = int'(DistMax);
      return RawW'(t);
    end
    if (roll < 90) return RawW'($urandom);
    case ($urandom_range(3))
      0:       return '0;
      1:       return RawW'(DistMax);
      2:       return RawW'(DistMax) + 1'b1;
      default: return '1;
    endcase
  endfunction

  initial begin : stimulus
    logic [RawW-1:0] raw;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgPropGain;
    cfg_wdata_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner readings under the reset register values.
    foreach (CornerDistances[i]) send_distance(CornerDistances[i]);

    // Random phases, each under its own register setting and idle pattern.
    for (int p = 0; p < NumPhases; p++) begin
      drain_pipeline();
      load_phase(p);
      case (idle_mode_e'(p % 4))
        IdleNone:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        IdleSender:   begin src_idle_pct = 80; sink_stall_pct = 0;  end
        IdleReceiver: begin src_idle_pct = 0;  sink_stall_pct = 80; end
        default:      begin src_idle_pct = 8;  sink_stall_pct = 8;  end
      endcase
      // Back-pressure: the sink refuses results while the source keeps going.
      if (p == 0) hold_requests++;
      raw = pick_distance();
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Repeated readings let the average settle onto its extremes.
        if ($urandom_range(99) >= 20) raw = pick_distance();
        send_distance(raw);
      end
    end

    drain_pipeline();
    repeat (PipeDepth * 4) @(posedge clk_i);
    $display("Sent %0d distance samples under %0d register settings.",
             sb.samples, settings_used);
    $display("Checked %0d results, %0d of them with the PID stage running.",
             sb.checked, sb.pid_runs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dpsc_pkg.sv
rtl/dpsc_avg.sv
rtl/dpsc_pid.sv
rtl/distance_pid_servo_controller_unit.sv
tb/testbench.sv
